// File: src/svs_pkg.sv
`default_nettype none

package svs_pkg;

	// Fixed field widths of the stream and configuration payloads.
	localparam int RATE_W     = 32;
	localparam int VF_W       = 31;
	localparam int GAMMA_W    = 31;
	localparam int OUTB_W     = 16;
	localparam int INIT_W     = 40;
	localparam int POP_W      = 31;
	localparam int NEWINF_W   = 40;
	localparam int SFRAC_W    = 31;
	localparam int S_TDATA_W  = 64;
	localparam int M_TDATA_W  = 72;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 40;

	// Binary point of the register and input fractions.
	localparam int Q30_BITS   = 30;
	// Binary point of the transmission rate.
	localparam int BETA_SHIFT = 28;
	// Counts are kept in 1/256 person.
	localparam int COUNT_FRAC = 8;
	// Multiplier digit width processed per cycle.
	localparam int DIG_W      = 8;

	// Configuration register indexes.
	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_RECOVERY_RATE      = 2'd0,
		CFG_OUTBREAK_INTERVAL  = 2'd1,
		CFG_INITIAL_INFECTIOUS = 2'd2,
		CFG_POPULATION         = 2'd3
	} cfg_idx_t;

	// Configuration register file contents.
	typedef struct packed {
		logic [GAMMA_W-1:0] recovery_rate;
		logic [OUTB_W-1:0]  outbreak_interval;
		logic [INIT_W-1:0]  initial_infectious;
		logic [POP_W-1:0]   population;
	} cfg_t;

	// One result item.
	typedef struct packed {
		logic [SFRAC_W-1:0]  susceptible_fraction;
		logic [NEWINF_W-1:0] new_infections;
	} res_t;

	// Sequencer states.
	typedef enum logic [3:0] {
		ST_IDLE,
		ST_CHECK,
		ST_MUL_SV,
		ST_DIV_VL,
		ST_MUL_BS,
		ST_MUL_BI,
		ST_MUL_GI,
		ST_MUL_CP,
		ST_DIV_SEED,
		ST_OUT
	} state_t;

endpackage

`default_nettype wire

// File: src/svs_mul.sv
`default_nettype none

// Digit-serial multiplier: one DIG_W-bit digit of b per cycle, shift-add
// into a product register that shifts right as the digits are consumed.
module svs_mul #(
	parameter int AW = 36,
	parameter int BW = 32
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  start,
	input  wire logic [AW-1:0]         a,
	input  wire logic [BW-1:0]         b,
	output logic                       done,
	output logic [AW+((BW+svs_pkg::DIG_W-1)/svs_pkg::DIG_W)*svs_pkg::DIG_W-1:0] prod
);

	localparam int DW   = svs_pkg::DIG_W;
	localparam int ND   = (BW + DW - 1) / DW;
	localparam int BPW  = ND * DW;
	localparam int PW   = AW + BPW;
	localparam int CNTW = $clog2(ND);

	logic [AW-1:0]    a_q;
	logic [PW-1:0]    p_q;
	logic [CNTW-1:0]  cnt_q;
	logic             busy_q;
	logic             done_q;
	logic [AW+DW-1:0] part;
	logic             last;

	// One partial product and the running upper sum.
	assign part = (AW + DW)'(p_q[PW-1:BPW])
		+ (AW + DW)'(a_q) * (AW + DW)'(p_q[DW-1:0]);
	assign last = (cnt_q == CNTW'(ND - 1));

	// Sequencing of the digit steps.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + CNTW'(1);
				if (last) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Operand and product registers.
	always_ff @(posedge clk) begin
		if (start) begin
			a_q <= a;
			p_q <= PW'(b);
		end else if (busy_q) begin
			p_q <= {part, p_q[BPW-1:DW]};
		end
	end

	assign done = done_q;
	assign prod = p_q;

endmodule

`default_nettype wire

// File: src/svs_div.sv
`default_nettype none

// Restoring divider, one quotient bit per cycle. The quotient is limited
// to QW bits; a dividend whose quotient would not fit returns all ones.
module svs_div #(
	parameter int PW = 70,
	parameter int DW = 39,
	parameter int QW = 33
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          start,
	input  wire logic [PW-1:0] dividend,
	input  wire logic [DW-1:0] divisor,
	output logic               done,
	output logic [QW-1:0]      quot
);

	localparam int HW   = PW - QW;
	localparam int CW   = (HW > DW) ? HW : DW;
	localparam int CNTW = $clog2(QW);

	logic [DW-1:0]   d_q;
	logic [DW-1:0]   rem_q;
	logic [QW-1:0]   lo_q;
	logic [CNTW-1:0] cnt_q;
	logic            busy_q;
	logic            done_q;
	logic [HW-1:0]   hi;
	logic            sat;
	logic [DW:0]     r2;
	logic [DW:0]     rdiff;
	logic            ge;

	// Overflow test on the upper part of the dividend.
	assign hi  = dividend[PW-1:QW];
	assign sat = (CW'(hi) >= CW'(divisor));

	// One trial subtraction.
	assign r2    = {rem_q, lo_q[QW-1]};
	assign rdiff = r2 - {1'b0, d_q};
	assign ge    = (r2 >= {1'b0, d_q});

	// Step sequencing.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				cnt_q <= '0;
				if (sat) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					busy_q <= 1'b1;
				end
			end else if (busy_q) begin
				cnt_q <= cnt_q + CNTW'(1);
				if (cnt_q == CNTW'(QW - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Partial remainder and quotient shift register.
	always_ff @(posedge clk) begin
		if (start) begin
			d_q   <= divisor;
			rem_q <= DW'(hi);
			lo_q  <= sat ? '1 : dividend[QW-1:0];
		end else if (busy_q) begin
			rem_q <= ge ? rdiff[DW-1:0] : r2[DW-1:0];
			lo_q  <= {lo_q[QW-2:0], ge};
		end
	end

	assign done = done_q;
	assign quot = lo_q;

endmodule

`default_nettype wire

// File: src/svs_seq.sv
`default_nettype none

// Interval sequencer: holds the epidemic state and steps one interval
// through the shared multiplier and divider.
module svs_seq #(
	parameter int FRACTION_BITS = 30,
	parameter int COUNT_WIDTH   = 16
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire svs_pkg::cfg_t                 cfg,
	input  wire logic                          in_valid,
	output logic                               in_ready,
	input  wire logic                          in_start,
	input  wire logic [svs_pkg::RATE_W-1:0]    in_beta,
	input  wire logic [svs_pkg::VF_W-1:0]      in_vf,
	output logic                               res_valid,
	input  wire logic                          res_ready,
	output svs_pkg::res_t                      res
);

	localparam int FB   = FRACTION_BITS;
	localparam int FW   = FB + 2;
	localparam int MAW  = FW + 4;
	localparam int MBW  = (FW > svs_pkg::RATE_W) ? FW : svs_pkg::RATE_W;
	localparam int MND  = (MBW + svs_pkg::DIG_W - 1) / svs_pkg::DIG_W;
	localparam int MPW  = MAW + MND * svs_pkg::DIG_W;
	localparam int DVW  = (FW + FB + 1 > svs_pkg::INIT_W + FB) ?
		(FW + FB + 1) : (svs_pkg::INIT_W + FB);
	localparam int DSW  = (FW > svs_pkg::POP_W + svs_pkg::COUNT_FRAC) ?
		FW : (svs_pkg::POP_W + svs_pkg::COUNT_FRAC);
	localparam int QW   = FW + 1;
	localparam int SHL  = (FB >= svs_pkg::Q30_BITS) ? (FB - svs_pkg::Q30_BITS) : 0;
	localparam int SHR  = (FB >= svs_pkg::Q30_BITS) ? 0 : (svs_pkg::Q30_BITS - FB);
	localparam int CVW  = svs_pkg::VF_W + SHL;
	localparam int SW   = (FW > svs_pkg::SFRAC_W) ? FW : svs_pkg::SFRAC_W;
	localparam int CMPW = (COUNT_WIDTH > svs_pkg::OUTB_W) ? COUNT_WIDTH : svs_pkg::OUTB_W;

	localparam logic [FW-1:0] ONE_FRAC = {{(FW - FB - 1){1'b0}}, 1'b1, {FB{1'b0}}};
	localparam logic [FW-1:0] FRAC_MAX = '1;
	localparam logic [COUNT_WIDTH-1:0] CNT_MAX = '1;
	localparam logic [svs_pkg::NEWINF_W-1:0] CNT_SAT = '1;

	svs_pkg::state_t state_q, state_d;
	logic issue_q;

	logic [FW-1:0]              s_q, i_q, u_q;
	logic [COUNT_WIDTH-1:0]     cnt_q;
	logic                       after_q, seed_q;
	logic [svs_pkg::RATE_W-1:0] beta_q;
	logic [FB:0]                vf_q;
	logic [FW-1:0]              rem_q, inf_q;
	logic [MAW-1:0]             inf1_q;
	svs_pkg::res_t              res_q;

	logic                       acc;
	logic [COUNT_WIDTH-1:0]     prev_cnt, next_cnt;
	logic                       after_c, seed_c;
	logic [FB:0]                vf_c, gamma_c;
	logic [svs_pkg::POP_W-1:0]  pop_nz;

	logic                       mul_start, mul_done;
	logic [MAW-1:0]             mul_a;
	logic [MBW-1:0]             mul_b;
	logic [MPW-1:0]             mul_prod;
	logic                       div_start, div_done;
	logic [DVW-1:0]             div_dividend;
	logic [DSW-1:0]             div_divisor;
	logic [QW-1:0]              div_quot;

	logic [MPW-1:0]             prod_fb, cnt_full;
	logic [FW-1:0]              remain_c, inf_c, rmv_c;
	logic [FW-1:0]              s_new, i_sub, i_new, u_sub, u_new;
	logic [FW-1:0]              nu_c, seed_s;
	logic [svs_pkg::NEWINF_W-1:0] count_c, seed_count;

	// Saturate an internal fraction to the result field.
	function automatic logic [svs_pkg::SFRAC_W-1:0] sat_frac(input logic [FW-1:0] x);
		logic [SW-1:0] xe;
		xe = SW'(x);
		if (xe > SW'({svs_pkg::SFRAC_W{1'b1}}))
			sat_frac = '1;
		else
			sat_frac = xe[svs_pkg::SFRAC_W-1:0];
	endfunction

	// Input conversions and the interval counter decision.
	assign acc      = in_valid && in_ready;
	assign vf_c     = (FB + 1)'((CVW'(in_vf) << SHL) >> SHR);
	assign gamma_c  = (FB + 1)'((CVW'(cfg.recovery_rate) << SHL) >> SHR);
	assign pop_nz   = (cfg.population == '0) ? svs_pkg::POP_W'(1) : cfg.population;
	assign prev_cnt = in_start ? '0 : cnt_q;
	assign next_cnt = (prev_cnt == CNT_MAX) ? prev_cnt : prev_cnt + COUNT_WIDTH'(1);
	assign after_c  = (CMPW'(prev_cnt) >= CMPW'(cfg.outbreak_interval));
	assign seed_c   = (CMPW'(next_cnt) == CMPW'(cfg.outbreak_interval));

	// Post-processing of unit results.
	assign prod_fb  = mul_prod >> FB;
	assign cnt_full = mul_prod >> (FB - svs_pkg::COUNT_FRAC);
	assign remain_c = (QW'(s_q) > div_quot) ? (s_q - div_quot[FW-1:0]) : '0;
	assign inf_c    = (prod_fb > MPW'(rem_q)) ? rem_q : prod_fb[FW-1:0];
	assign rmv_c    = (prod_fb > MPW'(i_q)) ? i_q : prod_fb[FW-1:0];
	assign s_new    = rem_q - inf_q;
	assign i_sub    = i_q - rmv_c;
	assign i_new    = (inf_q > FRAC_MAX - i_sub) ? FRAC_MAX : (i_sub + inf_q);
	assign u_sub    = (u_q > FW'(vf_q)) ? (u_q - FW'(vf_q)) : '0;
	assign u_new    = (u_sub < s_new) ? s_new : u_sub;
	assign count_c  = (cnt_full > MPW'(CNT_SAT)) ? CNT_SAT :
		((cnt_full == '0) ? svs_pkg::NEWINF_W'(1) : cnt_full[svs_pkg::NEWINF_W-1:0]);
	assign nu_c     = (div_quot > QW'(FRAC_MAX)) ? FRAC_MAX : div_quot[FW-1:0];
	assign seed_s   = (ONE_FRAC > nu_c) ? (ONE_FRAC - nu_c) : '0;
	assign seed_count = (cfg.initial_infectious == '0) ?
		svs_pkg::NEWINF_W'(1) : cfg.initial_infectious;

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			svs_pkg::ST_IDLE: begin
				if (acc)
					state_d = svs_pkg::ST_CHECK;
			end
			svs_pkg::ST_CHECK: begin
				if (after_q)
					state_d = (u_q != '0) ? svs_pkg::ST_MUL_SV : svs_pkg::ST_MUL_BS;
				else if (seed_q)
					state_d = svs_pkg::ST_DIV_SEED;
				else
					state_d = svs_pkg::ST_OUT;
			end
			svs_pkg::ST_MUL_SV: begin
				if (mul_done)
					state_d = svs_pkg::ST_DIV_VL;
			end
			svs_pkg::ST_DIV_VL: begin
				if (div_done)
					state_d = svs_pkg::ST_MUL_BS;
			end
			svs_pkg::ST_MUL_BS: begin
				if (mul_done)
					state_d = svs_pkg::ST_MUL_BI;
			end
			svs_pkg::ST_MUL_BI: begin
				if (mul_done)
					state_d = svs_pkg::ST_MUL_GI;
			end
			svs_pkg::ST_MUL_GI: begin
				if (mul_done)
					state_d = svs_pkg::ST_MUL_CP;
			end
			svs_pkg::ST_MUL_CP: begin
				if (mul_done)
					state_d = svs_pkg::ST_OUT;
			end
			svs_pkg::ST_DIV_SEED: begin
				if (div_done)
					state_d = svs_pkg::ST_OUT;
			end
			svs_pkg::ST_OUT: begin
				if (res_ready)
					state_d = svs_pkg::ST_IDLE;
			end
			default: state_d = svs_pkg::ST_IDLE;
		endcase
	end

	// Handshake and unit operand selection.
	always_comb begin
		in_ready     = (state_q == svs_pkg::ST_IDLE);
		res_valid    = (state_q == svs_pkg::ST_OUT);
		mul_start    = issue_q && (state_q inside {svs_pkg::ST_MUL_SV, svs_pkg::ST_MUL_BS,
			svs_pkg::ST_MUL_BI, svs_pkg::ST_MUL_GI, svs_pkg::ST_MUL_CP});
		div_start    = issue_q && (state_q inside {svs_pkg::ST_DIV_VL, svs_pkg::ST_DIV_SEED});
		mul_a        = MAW'(s_q);
		mul_b        = MBW'(vf_q);
		div_dividend = DVW'(mul_prod);
		div_divisor  = DSW'(u_q);
		case (state_q)
			svs_pkg::ST_MUL_BS: begin
				mul_b = MBW'(beta_q);
			end
			svs_pkg::ST_MUL_BI: begin
				mul_a = inf1_q;
				mul_b = MBW'(i_q);
			end
			svs_pkg::ST_MUL_GI: begin
				mul_a = MAW'(i_q);
				mul_b = MBW'(gamma_c);
			end
			svs_pkg::ST_MUL_CP: begin
				mul_a = MAW'(inf_q);
				mul_b = MBW'(pop_nz);
			end
			svs_pkg::ST_DIV_SEED: begin
				div_dividend = DVW'(cfg.initial_infectious) << FB;
				div_divisor  = DSW'({pop_nz, {svs_pkg::COUNT_FRAC{1'b0}}});
			end
			default: begin
			end
		endcase
	end

	// State register and the epidemic state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= svs_pkg::ST_IDLE;
			issue_q <= 1'b0;
			s_q     <= '0;
			i_q     <= '0;
			u_q     <= ONE_FRAC;
			cnt_q   <= '0;
			after_q <= 1'b0;
			seed_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			issue_q <= (state_d != state_q);
			case (state_q)
				svs_pkg::ST_IDLE: begin
					if (acc) begin
						cnt_q   <= next_cnt;
						after_q <= after_c;
						seed_q  <= seed_c;
						if (in_start) begin
							s_q <= '0;
							i_q <= '0;
							u_q <= ONE_FRAC;
						end
					end
				end
				svs_pkg::ST_MUL_GI: begin
					if (mul_done) begin
						s_q <= s_new;
						i_q <= i_new;
						u_q <= u_new;
					end
				end
				svs_pkg::ST_DIV_SEED: begin
					if (div_done) begin
						i_q <= nu_c;
						s_q <= seed_s;
						u_q <= ONE_FRAC;
					end
				end
				default: begin
				end
			endcase
		end
	end

	// Working values and the result.
	always_ff @(posedge clk) begin
		case (state_q)
			svs_pkg::ST_IDLE: begin
				if (acc) begin
					beta_q <= in_beta;
					vf_q   <= vf_c;
				end
			end
			svs_pkg::ST_CHECK: begin
				// No vaccination loss when the unvaccinated fraction is zero.
				if (after_q && (u_q == '0))
					rem_q <= s_q;
				if (!after_q && !seed_q) begin
					res_q.new_infections       <= svs_pkg::NEWINF_W'(1);
					res_q.susceptible_fraction <= sat_frac(ONE_FRAC);
				end
			end
			svs_pkg::ST_DIV_VL: begin
				if (div_done)
					rem_q <= remain_c;
			end
			svs_pkg::ST_MUL_BS: begin
				if (mul_done)
					inf1_q <= MAW'(mul_prod >> svs_pkg::BETA_SHIFT);
			end
			svs_pkg::ST_MUL_BI: begin
				if (mul_done)
					inf_q <= inf_c;
			end
			svs_pkg::ST_MUL_CP: begin
				if (mul_done) begin
					res_q.new_infections       <= count_c;
					res_q.susceptible_fraction <= sat_frac(s_q);
				end
			end
			svs_pkg::ST_DIV_SEED: begin
				if (div_done) begin
					res_q.new_infections       <= seed_count;
					res_q.susceptible_fraction <= sat_frac(seed_s);
				end
			end
			default: begin
			end
		endcase
	end

	assign res = res_q;

	// Shared arithmetic units.
	svs_mul #(
		.AW(MAW),
		.BW(MBW)
	) u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mul_start),
		.a      (mul_a),
		.b      (mul_b),
		.done   (mul_done),
		.prod   (mul_prod)
	);

	svs_div #(
		.PW(DVW),
		.DW(DSW),
		.QW(QW)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.done     (div_done),
		.quot     (div_quot)
	);

endmodule

`default_nettype wire

// File: src/sir_vaccination_step_core.sv
`default_nettype none

// Channel   Dir  Handshake                      Payload
// s_axis    in   s_axis_tvalid/s_axis_tready    tdata: rate, vaccinated; tuser: start
// m_axis    out  m_axis_tvalid/m_axis_tready    tdata: new infections, susceptible
// cfg       in   cfg_valid/cfg_ready            cfg_index, cfg_data
//
// An interval after the outbreak runs five multiplies through the shared 8-bit-digit
// multiplier and one quotient through the bit-serial divider between one accepted beat
// and the next. A quotient that overflows ends the divide without its bit steps, and a
// zero unvaccinated fraction skips the first multiply and the divide. The seeding
// interval runs one divide, and an interval before the outbreak goes straight to the
// output. Reset clears the state and sets the registers to their defaults at once. A
// stalled result is held in the output register while the next item is taken.
module sir_vaccination_step_core #(
	parameter int FRACTION_BITS = 30,
	parameter int COUNT_WIDTH   = 16
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            s_axis_tvalid,
	output logic                                 s_axis_tready,
	// [31:0] transmission_rate, [62:32] vaccinated_fraction, [63] zero
	input  wire logic [svs_pkg::S_TDATA_W-1:0]   s_axis_tdata,
	// [0] series_start
	input  wire logic [0:0]                      s_axis_tuser,
	output logic                                 m_axis_tvalid,
	input  wire logic                            m_axis_tready,
	// [39:0] new_infections, [70:40] susceptible_fraction, [71] zero
	output logic [svs_pkg::M_TDATA_W-1:0]        m_axis_tdata,
	input  wire logic                            cfg_valid,
	output logic                                 cfg_ready,
	input  wire logic [svs_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  wire logic [svs_pkg::CFG_DATA_W-1:0]  cfg_data
);

	svs_pkg::cfg_t cfg_q;
	svs_pkg::res_t res;
	logic          res_valid;
	logic          res_ready;
	logic          m_valid_q;
	svs_pkg::res_t m_data_q;

	// Configuration registers.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.recovery_rate      <= '0;
			cfg_q.outbreak_interval  <= svs_pkg::OUTB_W'(1);
			cfg_q.initial_infectious <= svs_pkg::INIT_W'(256);
			cfg_q.population         <= svs_pkg::POP_W'(1);
		end else if (cfg_valid && cfg_ready) begin
			case (svs_pkg::cfg_idx_t'(cfg_index))
				svs_pkg::CFG_RECOVERY_RATE:
					cfg_q.recovery_rate <= cfg_data[svs_pkg::GAMMA_W-1:0];
				svs_pkg::CFG_OUTBREAK_INTERVAL:
					cfg_q.outbreak_interval <= cfg_data[svs_pkg::OUTB_W-1:0];
				svs_pkg::CFG_INITIAL_INFECTIOUS:
					cfg_q.initial_infectious <= cfg_data[svs_pkg::INIT_W-1:0];
				svs_pkg::CFG_POPULATION:
					cfg_q.population <= cfg_data[svs_pkg::POP_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// Interval sequencer with the shared arithmetic units.
	svs_seq #(
		.FRACTION_BITS (FRACTION_BITS),
		.COUNT_WIDTH   (COUNT_WIDTH)
	) u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.in_start  (s_axis_tuser[0]),
		.in_beta   (s_axis_tdata[svs_pkg::RATE_W-1:0]),
		.in_vf     (s_axis_tdata[svs_pkg::RATE_W +: svs_pkg::VF_W]),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res)
	);

	// Output register: a result beat waits here until it is taken.
	assign res_ready = !m_valid_q || m_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (res_ready) begin
			m_valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_ready && res_valid)
			m_data_q <= res;
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = {1'b0, m_data_q.susceptible_fraction, m_data_q.new_infections};

endmodule

`default_nettype wire

// File: src/svs_chk.sv
`default_nettype none

// Port-level checks of the interval core.
module svs_chk (
	input wire logic                            clk,
	input wire logic                            arst_n,
	input wire logic                            s_axis_tvalid,
	input wire logic                            s_axis_tready,
	input wire logic                            m_axis_tvalid,
	input wire logic                            m_axis_tready,
	input wire logic [svs_pkg::M_TDATA_W-1:0]   m_axis_tdata,
	input wire logic                            cfg_ready
);

	// A stalled result beat holds its value.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("result beat changed while stalled");

	// An accepted item occupies the sequencer for at least the next cycle.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
		else $error("input taken again right after an accept");

	// The infection count is floored at one LSB.
	a_count_floor: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tdata[svs_pkg::NEWINF_W-1:0] != '0)
		else $error("new infections reported as zero");

	// Configuration writes are never stalled.
	a_cfg_ready: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_ready)
		else $error("configuration port stalled");

endmodule

bind sir_vaccination_step_core svs_chk u_svs_chk (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.cfg_ready     (cfg_ready)
);

`default_nettype wire
